[hw/rtl/mtlc_pkg.sv]
// types and constants shared by the multitrack looper modules
`default_nettype none

package mtlc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int REM_NUM_W = 27;
  localparam int REM_DEN_W = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TRACK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_LEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_ROW,
    S_MIX,
    S_WR,
    S_LWAIT,
    S_C1,
    S_C2,
    S_C3,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [REM_NUM_W-1:0] num;
    logic [REM_DEN_W-1:0] den;
  } rem_req_t;

  typedef struct packed {
    logic                 done;
    logic [REM_DEN_W-1:0] rem;
  } rem_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/mtlc_rem.sv]
// iterative restoring remainder unit, one dividend bit per cycle
`default_nettype none

module mtlc_rem (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mtlc_pkg::rem_req_t  req,
  output mtlc_pkg::rem_rsp_t       rsp
);

  localparam int NW = mtlc_pkg::REM_NUM_W;
  localparam int DW = mtlc_pkg::REM_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [DW:0]   part;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fast;

  assign trial = {part[DW-1:0], num[NW-1]};
  assign diff = trial - {1'b0, den};
  assign fast = req.num < {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= !fast;
      done <= fast;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (fast) begin
        part <= (DW + 1)'(req.num);
      end else begin
        part <= '0;
        num <= req.num;
        den <= req.den;
        cnt <= CW'(NW);
      end
    end else if (busy) begin
      part <= (trial >= {1'b0, den}) ? diff : trial;
      num <= num << 1;
      cnt <= cnt - CW'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.rem = part[DW-1:0];

endmodule

`default_nettype wire

[hw/rtl/multitrack_looper_with_click.sv]
// top level of the multitrack looper with overdub and metronome click
`default_nettype none

// One sample item in, one mixed sample item out. The block takes an item only
// when its sequencer is idle and holds the result in an output register, so a
// new item can be taken while the last result still waits. When the shared
// remainder unit answers at once, one item goes through these steps: take it,
// form the loop length, read the track row, add each track in turn, write the
// row back, collect the loop wrap and hand out the result. Each remainder is
// answered at once when the value is already below the length, else it is
// worked out one dividend bit at a time. The loop wrap runs beside the track
// adds, so a slow one, on the last loop position, stretches the item. With the
// click enabled and a nonzero bar length three more remainders follow, of
// which the two beat-phase ones are normally slow. A stalled output holds the
// item in its last step. The track memory holds one row of all tracks per loop
// position, one read and at most one write per item. There is no clearing pass
// after reset: a fill count marks the rows touched so far and rows at or above
// it read as silence.
module multitrack_looper_with_click #(
  parameter int NUM_TRACKS = 4,
  parameter int LOOP_DEPTH = 1048576
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [15:0]                       s_tdata,   // sample_in
  input  wire logic [0:0]                        s_tuser,   // record
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [15:0]                            m_tdata,   // sample_out
  input  wire logic                              cfg_we,
  input  wire logic [mtlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mtlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(LOOP_DEPTH);
  localparam int FW = $clog2(LOOP_DEPTH + 1);
  localparam int ROW_W = NUM_TRACKS * 16;
  localparam int KW = $clog2(NUM_TRACKS + 1);
  localparam int ACC_W = 17 + $clog2(NUM_TRACKS + 2);

  // configuration
  logic [16:0] beat_length;
  logic [6:0]  bar_count;
  logic [1:0]  active_track;
  logic        click_enable;
  logic [14:0] click_gain;
  logic [15:0] click_len;
  logic [14:0] phase_step;

  mtlc_pkg::state_t state, state_next;

  logic signed [15:0]      x;
  logic                    rec;
  logic signed [ACC_W-1:0] acc;
  logic [23:0]             bar_len;
  logic [ROW_W-1:0]        row;
  logic [ROW_W-1:0]        lanes;
  logic [KW-1:0]           kcnt;
  logic [25:0]             lp;
  logic [23:0]             cp;
  logic [15:0]             phase;
  logic [FW-1:0]           fill;
  logic                    accent;

  logic [ROW_W-1:0] mem [LOOP_DEPTH];
  logic [ROW_W-1:0] rd_data;

  mtlc_pkg::rem_req_t rem_req;
  mtlc_pkg::rem_rsp_t rem_rsp;

  logic [23:0]        bar_prod;
  logic [25:0]        loop_len;
  logic               in_mem;
  logic               row_ok;
  logic               at_fill;
  logic               act_ok;
  logic signed [15:0] old_lane;
  logic signed [16:0] dub_sum;
  logic [15:0]        dub_lane;
  logic [ROW_W-1:0]   row_new;
  logic               mem_we;
  logic               loop_ready;
  logic [16:0]        len_eff;
  logic [15:0]        step_eff;
  logic [15:0]        gain_ext;
  logic signed [15:0] click_val;
  logic               sound;
  logic [15:0]        sat_out;
  logic               out_free;

  mtlc_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign bar_prod = {7'd0, beat_length} * {17'd0, bar_count};
  assign loop_len = {bar_len, 2'b00};
  assign in_mem = lp < 26'(LOOP_DEPTH);
  assign row_ok = lp < 26'(fill);
  assign at_fill = lp == 26'(fill);
  assign act_ok = {3'd0, active_track} < 5'(NUM_TRACKS);
  assign loop_ready = (loop_len == 26'd0) || rem_rsp.done;
  assign out_free = !m_tvalid || m_tready;

  // overdub of the active lane
  always_comb begin
    old_lane = '0;
    for (int t = 0; t < NUM_TRACKS; t++) begin
      if ({3'd0, active_track} == 5'(t)) begin
        old_lane = row[t*16 +: 16];
      end
    end
    dub_sum = {old_lane[15], old_lane} + {x[15], x};
    if (dub_sum > 17'sd32767) begin
      dub_lane = 16'h7fff;
    end else if (dub_sum < -17'sd32768) begin
      dub_lane = 16'h8000;
    end else begin
      dub_lane = dub_sum[15:0];
    end
    row_new = row;
    for (int t = 0; t < NUM_TRACKS; t++) begin
      if (rec && act_ok && {3'd0, active_track} == 5'(t)) begin
        row_new[t*16 +: 16] = dub_lane;
      end
    end
  end

  assign mem_we = (state == mtlc_pkg::S_WR) && in_mem && (at_fill || (rec && act_ok));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[lp[AW-1:0]] <= row_new;
    end
    rd_data <= mem[lp[AW-1:0]];
  end

  // click tone
  assign len_eff = accent ? {click_len, 1'b0} : {1'b0, click_len};
  assign step_eff = accent ? {phase_step, 1'b0} : {1'b0, phase_step};
  assign gain_ext = {1'b0, click_gain};
  assign click_val = phase[15] ? $signed(16'd0 - gain_ext) : $signed(gain_ext);
  assign sound = rem_rsp.rem < 26'(len_eff);

  always_comb begin
    if (acc > ACC_W'(32767)) begin
      sat_out = 16'h7fff;
    end else if (acc < -ACC_W'(32768)) begin
      sat_out = 16'h8000;
    end else begin
      sat_out = acc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_length <= 17'd24000;
      bar_count <= 7'd8;
      active_track <= 2'd0;
      click_enable <= 1'b0;
      click_gain <= 15'd1638;
      click_len <= 16'd1200;
      phase_step <= 15'd1201;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtlc_pkg::CFG_BEAT_LENGTH:  beat_length <= cfg_data;
        mtlc_pkg::CFG_BAR_COUNT:    bar_count <= cfg_data[6:0];
        mtlc_pkg::CFG_ACTIVE_TRACK: active_track <= cfg_data[1:0];
        mtlc_pkg::CFG_CLICK_ENABLE: click_enable <= cfg_data[0];
        mtlc_pkg::CFG_CLICK_GAIN:   click_gain <= cfg_data[14:0];
        mtlc_pkg::CFG_CLICK_LEN:    click_len <= cfg_data[15:0];
        mtlc_pkg::CFG_PHASE_STEP:   phase_step <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtlc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    rem_req.start = 1'b0;
    rem_req.num = '0;
    rem_req.den = '0;
    unique case (state)
      mtlc_pkg::S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = mtlc_pkg::S_LEN;
        end
      end
      mtlc_pkg::S_LEN: begin
        state_next = mtlc_pkg::S_ROW;
      end
      mtlc_pkg::S_ROW: begin
        rem_req.start = loop_len != 26'd0;
        rem_req.num = {1'b0, lp} + 27'd1;
        rem_req.den = loop_len;
        state_next = mtlc_pkg::S_MIX;
      end
      mtlc_pkg::S_MIX: begin
        if (kcnt == KW'(1)) begin
          state_next = mtlc_pkg::S_WR;
        end
      end
      mtlc_pkg::S_WR: begin
        state_next = mtlc_pkg::S_LWAIT;
      end
      mtlc_pkg::S_LWAIT: begin
        if (loop_ready) begin
          if (!click_enable || bar_len == 24'd0) begin
            state_next = mtlc_pkg::S_OUT;
          end else begin
            rem_req.start = 1'b1;
            rem_req.num = {3'd0, cp};
            rem_req.den = {7'd0, beat_length, 2'b00};
            state_next = mtlc_pkg::S_C1;
          end
        end
      end
      mtlc_pkg::S_C1: begin
        if (rem_rsp.done) begin
          rem_req.start = 1'b1;
          rem_req.num = {3'd0, cp};
          rem_req.den = {9'd0, beat_length};
          state_next = mtlc_pkg::S_C2;
        end
      end
      mtlc_pkg::S_C2: begin
        if (rem_rsp.done) begin
          rem_req.start = 1'b1;
          rem_req.num = {3'd0, cp} + 27'd1;
          rem_req.den = {2'd0, bar_len};
          state_next = mtlc_pkg::S_C3;
        end
      end
      mtlc_pkg::S_C3: begin
        if (rem_rsp.done) begin
          state_next = mtlc_pkg::S_OUT;
        end
      end
      mtlc_pkg::S_OUT: begin
        if (out_free) begin
          state_next = mtlc_pkg::S_IDLE;
        end
      end
      default: state_next = mtlc_pkg::S_IDLE;
    endcase
  end

  // control counters and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0;
      cp <= '0;
      phase <= '0;
      fill <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == mtlc_pkg::S_WR && in_mem && at_fill) begin
        fill <= fill + FW'(1);
      end
      if (state == mtlc_pkg::S_LWAIT && loop_ready) begin
        lp <= (loop_len == 26'd0) ? 26'd0 : rem_rsp.rem;
        if (click_enable && bar_len == 24'd0) begin
          cp <= '0;
          phase <= phase + {1'b0, phase_step};
        end
      end
      if (state == mtlc_pkg::S_C2 && rem_rsp.done) begin
        phase <= phase + step_eff;
      end
      if (state == mtlc_pkg::S_C3 && rem_rsp.done) begin
        cp <= rem_rsp.rem[23:0];
      end
      if (state == mtlc_pkg::S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mtlc_pkg::S_IDLE: begin
        x <= $signed(s_tdata);
        rec <= s_tuser[0];
        acc <= ACC_W'($signed(s_tdata));
      end
      mtlc_pkg::S_LEN: begin
        bar_len <= bar_prod;
      end
      mtlc_pkg::S_ROW: begin
        row <= row_ok ? rd_data : '0;
        lanes <= row_ok ? rd_data : '0;
        kcnt <= KW'(NUM_TRACKS);
      end
      mtlc_pkg::S_MIX: begin
        if (in_mem) begin
          acc <= acc + ACC_W'($signed(lanes[15:0]));
        end
        lanes <= lanes >> 16;
        kcnt <= kcnt - KW'(1);
      end
      mtlc_pkg::S_C1: begin
        if (rem_rsp.done) begin
          accent <= rem_rsp.rem < {9'd0, beat_length};
        end
      end
      mtlc_pkg::S_C2: begin
        if (rem_rsp.done && sound) begin
          acc <= acc + ACC_W'(click_val);
        end
      end
      mtlc_pkg::S_OUT: begin
        if (out_free) begin
          m_tdata <= sat_out;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[bench/looper_mix_checker.sv]
// checker for the multitrack looper: predicts each mixed sample and compares it
`timescale 1ns / 100ps

module looper_mix_checker
  import mtlc_pkg::*;
#(
  parameter int NUM_TRACKS = 4,
  parameter int LOOP_DEPTH = 1048576
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [15:0]           s_tdata,   // sample_in
  input  logic [0:0]            s_tuser,   // record
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [15:0]           m_tdata,   // sample_out
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    waiting
);

  // track samples keyed by track * LOOP_DEPTH + position, absent means silence
  shortint     track_mem [int unsigned];
  int unsigned loop_pos;
  int unsigned click_pos;
  int unsigned click_ph;

  int unsigned beat_len;
  int unsigned bars;
  int unsigned active;
  int unsigned click_on;
  int unsigned gain;
  int unsigned clen;
  int unsigned step;

  logic [15:0] mixed_q [$];
  logic [15:0] want;

  initial begin
    mismatches = 0;
    waiting = 0;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void clear_model();
    track_mem.delete();
    mixed_q.delete();
    loop_pos = 0;
    click_pos = 0;
    click_ph = 0;
    beat_len = 24000;
    bars = 8;
    active = 0;
    click_on = 0;
    gain = 1638;
    clen = 1200;
    step = 1201;
  endfunction

  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BEAT_LENGTH:  beat_len = data[16:0];
      CFG_BAR_COUNT:    bars = data[6:0];
      CFG_ACTIVE_TRACK: active = data[1:0];
      CFG_CLICK_ENABLE: click_on = data[0];
      CFG_CLICK_GAIN:   gain = data[14:0];
      CFG_CLICK_LEN:    clen = data[15:0];
      CFG_PHASE_STEP:   step = data[14:0];
      default: ;
    endcase
  endfunction

  // square-wave metronome tone, advances the click timer and phase
  function automatic int click_tone();
    int          val;
    int unsigned bar_len;
    int unsigned len;
    int unsigned stp;
    int unsigned pos;
    val = 0;
    bar_len = beat_len * bars;
    len = clen;
    stp = step;
    if (beat_len != 0 && bar_len != 0) begin
      pos = click_pos;
      if ((pos % (4 * beat_len)) < beat_len) begin
        len = 2 * clen;
        stp = 2 * step;
      end
      if ((pos % beat_len) < len)
        val = (click_ph < 32'h8000) ? int'(gain) : -int'(gain);
      click_pos = (pos + 1) % bar_len;
    end else begin
      click_pos = 0;
    end
    click_ph = (click_ph + stp) & 32'hffff;
    return val;
  endfunction

  function automatic logic [15:0] mix_sample(input logic [15:0] smp, input logic rec);
    int          x;
    int          acc;
    int          old;
    int unsigned key;
    int unsigned loop_len;
    x = $signed(smp);
    acc = x;
    loop_len = beat_len * bars * 4;
    if (loop_pos < LOOP_DEPTH) begin
      for (int unsigned t = 0; t < NUM_TRACKS; t++) begin
        key = t * LOOP_DEPTH + loop_pos;
        old = track_mem.exists(key) ? int'(track_mem[key]) : 0;
        acc += old;
        if (rec && t == active)
          track_mem[key] = shortint'(clamp16(old + x));
      end
    end
    loop_pos = (loop_len != 0) ? (loop_pos + 1) % loop_len : 0;
    if (click_on != 0)
      acc += click_tone();
    return 16'(clamp16(acc));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      if (m_tvalid && m_tready) begin
        if (mixed_q.size() == 0) begin
          mismatches++;
          $error("sample_out: expected none, actual %0d", $signed(m_tdata));
        end else begin
          want = mixed_q.pop_front();
          if (m_tdata !== want) begin
            mismatches++;
            $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(m_tdata));
          end
        end
      end
      if (s_tvalid && s_tready)
        mixed_q = {mixed_q, mix_sample(s_tdata, s_tuser[0])};
      if (cfg_we)
        set_reg(cfg_index, cfg_data);
    end
    waiting = mixed_q.size();
  end

endmodule

[bench/multitrack_looper_with_click_tb.sv]
// testbench top for the multitrack looper: stimulus, idling and verdict
`timescale 1ns / 100ps

module multitrack_looper_with_click_tb;
  import mtlc_pkg::*;

  localparam int NUM_TRACKS = 4;
  localparam int LOOP_DEPTH = 1048576;
  localparam int ITEM_TARGET = 1250;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // sample_in
  logic [0:0]            s_tuser = '0;   // record
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // sample_out
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int waiting;
  int items_sent = 0;
  int idle_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  multitrack_looper_with_click #(
    .NUM_TRACKS(NUM_TRACKS),
    .LOOP_DEPTH(LOOP_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  looper_mix_checker #(
    .NUM_TRACKS(NUM_TRACKS),
    .LOOP_DEPTH(LOOP_DEPTH)
  ) u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_sample();
    int mag;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      1, 2: begin
        mag = $urandom_range(24576, 32767);
        return $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] smp, input logic rec);
    int gap;
    gap = (tx_calm || $urandom_range(0, 1)) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tuser <= rec;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // lower valid and wait until every expected item has come back
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // written most of the time, sometimes with junk above the register width
  task automatic maybe_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int width);
    int unsigned data;
    data = value;
    if ($urandom_range(0, 3) == 0)
      data = data | ($urandom << width);
    if ($urandom_range(0, 99) < 85)
      write_reg(idx, data);
  endtask

  task automatic random_setting();
    int unsigned beat;
    int unsigned bar;
    int unsigned gain;
    int unsigned clen;
    int unsigned step;
    int          r;
    r = $urandom_range(0, 99);
    beat = (r < 8) ? 0 : (r < 16) ? 131071 : $urandom_range(1, 12);
    r = $urandom_range(0, 99);
    bar = (r < 8) ? 0 : (r < 14) ? 64 : $urandom_range(1, 3);
    r = $urandom_range(0, 99);
    gain = (r < 10) ? 0 : (r < 20) ? 32767 : $urandom_range(0, 32767);
    r = $urandom_range(0, 99);
    if (r < 10)
      clen = 0;
    else if (r < 20)
      clen = 65535;
    else
      clen = (beat > 30000) ? $urandom_range(0, 65535) : $urandom_range(0, 2 * beat + 2);
    r = $urandom_range(0, 99);
    step = (r < 10) ? 0 : (r < 20) ? 32767 : $urandom_range(0, 32767);
    maybe_write(CFG_BEAT_LENGTH, beat, 17);
    maybe_write(CFG_BAR_COUNT, bar, 7);
    maybe_write(CFG_ACTIVE_TRACK, $urandom_range(0, 3), 2);
    maybe_write(CFG_CLICK_ENABLE, ($urandom_range(0, 3) != 0), 1);
    maybe_write(CFG_CLICK_GAIN, gain, 15);
    maybe_write(CFG_CLICK_LEN, clen, 16);
    maybe_write(CFG_PHASE_STEP, step, 15);
    close_writes();
  endtask

  // receiver back-pressure, with calm stretches where no new stall starts
  initial begin
    int stall_left;
    int stretch;
    stall_left = 0;
    stretch = 0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(50, 400);
      end
      stretch--;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0)
          stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int rec_pct;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, extremes of the input
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b1);
    settle();

    // shortest loop, loudest click, overdub saturates
    write_reg(CFG_BEAT_LENGTH, 1);
    write_reg(CFG_BAR_COUNT, 1);
    write_reg(CFG_ACTIVE_TRACK, 1);
    write_reg(CFG_CLICK_ENABLE, 1);
    write_reg(CFG_CLICK_GAIN, 32767);
    write_reg(CFG_CLICK_LEN, 65535);
    write_reg(CFG_PHASE_STEP, 32767);
    write_reg(CFG_SPARE, 17'h1ffff);
    close_writes();
    repeat (8) send_sample(16'h7fff, 1'b1);
    settle();

    write_reg(CFG_ACTIVE_TRACK, 3);
    close_writes();
    repeat (4) send_sample(16'h8000, 1'b1);
    settle();

    // zero beat length
    write_reg(CFG_BEAT_LENGTH, 0);
    close_writes();
    repeat (3) send_sample(pick_sample(), 1'b1);
    settle();

    // zero bar count
    write_reg(CFG_BEAT_LENGTH, 5);
    write_reg(CFG_BAR_COUNT, 0);
    close_writes();
    repeat (3) send_sample(pick_sample(), 1'b1);
    settle();

    // silent click, no phase movement
    write_reg(CFG_BAR_COUNT, 2);
    write_reg(CFG_CLICK_LEN, 0);
    write_reg(CFG_CLICK_GAIN, 0);
    write_reg(CFG_PHASE_STEP, 0);
    close_writes();
    repeat (3) send_sample(pick_sample(), 1'b0);

    while (items_sent < ITEM_TARGET) begin
      settle();
      random_setting();
      tx_calm = ($urandom_range(0, 3) == 0);
      rec_pct = ($urandom_range(0, 3) == 0) ? 20 : 80;
      n = $urandom_range(10, 60);
      repeat (n) send_sample(pick_sample(), ($urandom_range(0, 99) < rec_pct));
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mtlc_pkg.sv
hw/rtl/mtlc_rem.sv
hw/rtl/multitrack_looper_with_click.sv
bench/looper_mix_checker.sv
bench/multitrack_looper_with_click_tb.sv
